FILE: src/wll_pkg.sv
// wll_pkg: shared types and constants for the watershed link lookup block.
// Holds action codes, register indexes, flow-direction steps and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package wll_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CELL = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_LINK    = 8'd3;

  localparam logic [3:0] DIR_NW = 4'd0;
  localparam logic [3:0] DIR_N  = 4'd1;
  localparam logic [3:0] DIR_NE = 4'd2;
  localparam logic [3:0] DIR_W  = 4'd3;
  localparam logic [3:0] DIR_E  = 4'd4;
  localparam logic [3:0] DIR_SW = 4'd5;
  localparam logic [3:0] DIR_S  = 4'd6;
  localparam logic [3:0] DIR_SE = 4'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_APP_STEP,
    S_APP_ADDR,
    S_APP_WR,
    S_Q_RD,
    S_Q_CAP,
    S_SCAN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic latch;
    logic clear;
    logic ras_wr;
    logic app_step;
    logic app_addr;
    logic app_wr;
    logic q_rd;
    logic q_cap;
    logic scan;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic q_bad;
    logic scan_end;
    logic out_free;
  } sts_t;

  // Row offset of one step; no-move codes give zero.
  function automatic logic signed [1:0] step_row(input logic [3:0] dir);
    logic signed [1:0] d;
    case (dir)
      DIR_NW, DIR_N, DIR_NE: d = -2'sd1;
      DIR_SW, DIR_S, DIR_SE: d = 2'sd1;
      default:               d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] step_col(input logic [3:0] dir);
    logic signed [1:0] d;
    case (dir)
      DIR_NW, DIR_W, DIR_SW: d = -2'sd1;
      DIR_NE, DIR_E, DIR_SE: d = 2'sd1;
      default:               d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

FILE: src/wll_ram.sv
// wll_ram: generic simple dual-port RAM, one write and one registered read.
// Width and depth are parameters. No dependencies.
`timescale 1ns / 1ps

module wll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/wll_ctrl.sv
// wll_ctrl: controller state machine of the watershed link lookup block.
// Sequences cell writes, outlet appends and queries. Depends on wll_pkg.
`timescale 1ns / 1ps

module wll_ctrl
  import wll_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  input  sts_t       sts_i,
  output logic       in_stall_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (action_e'(action_i))
            ACT_WRITE:  state_d = S_WRITE;
            ACT_APPEND: state_d = S_APP_STEP;
            ACT_QUERY:  state_d = S_Q_RD;
            ACT_CLEAR:  cmd_o.clear = 1'b1;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd_o.ras_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_APP_STEP: begin
        cmd_o.app_step = 1'b1;
        state_d        = S_APP_ADDR;
      end
      S_APP_ADDR: begin
        cmd_o.app_addr = 1'b1;
        state_d        = S_APP_WR;
      end
      S_APP_WR: begin
        cmd_o.app_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_Q_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = sts_i.q_bad ? S_OUT : S_Q_CAP;
      end
      S_Q_CAP: begin
        cmd_o.q_cap = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: src/wll_dp.sv
// wll_dp: datapath of the watershed link lookup block: config registers,
// raster and outlet RAMs, downstream step, upstream scan, output register.
// Depends on wll_pkg and wll_ram.
`timescale 1ns / 1ps

module wll_dp
  import wll_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_OUTLETS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [15:0]          cell_index_i,
  input  logic signed [31:0]   cell_shed_id_i,
  input  logic [7:0]           outlet_row_i,
  input  logic [7:0]           outlet_col_i,
  input  logic [3:0]           outlet_dir_i,
  input  logic signed [31:0]   outlet_id_i,
  input  logic [7:0]           query_index_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic signed [31:0]   self_id_o,
  output logic signed [31:0]   up_id_o,
  output logic signed [31:0]   down_id_o,
  output logic                 status_o
);

  localparam int unsigned RDEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned RA_W   = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int unsigned OA_W   = (MAX_OUTLETS > 1) ? $clog2(MAX_OUTLETS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_OUTLETS + 1);

  // configuration
  logic [8:0]  grid_rows_q, grid_cols_q;
  logic [31:0] empty_q, nolink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= 9'd256;
      grid_cols_q <= 9'd256;
      empty_q     <= 32'd0;
      nolink_q    <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_ROWS:  grid_rows_q <= cfg_data_i[8:0];
        REG_GRID_COLS:  grid_cols_q <= cfg_data_i[8:0];
        REG_EMPTY_CELL: empty_q     <= cfg_data_i;
        REG_NO_LINK:    nolink_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request fields
  logic [15:0] cidx_q;
  logic [31:0] cval_q, oid_q;
  logic [7:0]  row_q, col_q, qidx_q;
  logic [3:0]  dir_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cidx_q <= cell_index_i;
      cval_q <= cell_shed_id_i;
      row_q  <= outlet_row_i;
      col_q  <= outlet_col_i;
      dir_q  <= outlet_dir_i;
      oid_q  <= outlet_id_i;
      qidx_q <= query_index_i;
    end
  end

  // outlet count
  logic [CNT_W-1:0] cnt_q;
  logic             full;

  assign full = 32'(cnt_q) >= MAX_OUTLETS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
    end else if (cmd_i.app_wr && !full) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // downstream step: bounds and row product
  logic [8:0]        rows_eff, cols_eff;
  logic signed [9:0] row_s, col_s;
  logic              oob;
  logic [17:0]       prod_q;
  logic [8:0]        colv_q;
  logic              oob_q, link_ok_q;
  logic [18:0]       sum;
  logic [31:0]       sum_w;
  logic              sum_ok;

  assign rows_eff = (32'(grid_rows_q) > MAX_ROWS) ? 9'(MAX_ROWS) : grid_rows_q;
  assign cols_eff = (32'(grid_cols_q) > MAX_COLS) ? 9'(MAX_COLS) : grid_cols_q;
  assign row_s    = $signed({2'b00, row_q}) + 10'(step_row(dir_q));
  assign col_s    = $signed({2'b00, col_q}) + 10'(step_col(dir_q));
  assign oob      = (row_s < 10'sd0) || (row_s >= $signed({1'b0, rows_eff}))
                 || (col_s < 10'sd0) || (col_s >= $signed({1'b0, cols_eff}));
  assign sum      = 19'(prod_q) + 19'(colv_q);
  assign sum_w    = 32'(sum);
  assign sum_ok   = sum_w < 32'(RDEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.app_step) begin
      prod_q <= 18'(row_s[8:0]) * 18'(cols_eff);
      colv_q <= col_s[8:0];
      oob_q  <= oob;
    end
    if (cmd_i.app_addr) begin
      link_ok_q <= !oob_q && sum_ok;
    end
  end

  // raster
  logic [31:0] cidx_w;
  logic [31:0] ras_rd;
  logic        cell_ok;

  assign cidx_w  = 32'(cidx_q);
  assign cell_ok = cidx_w < 32'(RDEPTH);

  wll_ram #(.WIDTH(32), .DEPTH(RDEPTH)) u_raster (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ras_wr && cell_ok),
    .waddr_i(cidx_w[RA_W-1:0]),
    .wdata_i(cval_q),
    .re_i   (cmd_i.app_addr),
    .raddr_i(sum_w[RA_W-1:0]),
    .rdata_o(ras_rd)
  );

  // outlet tables
  logic [31:0]      down_val, self_rd, down_rd, cnt_w, qidx_w, j_w;
  logic [CNT_W-1:0] j_q;
  logic             pend_q, issue, hit, o_re;
  logic [OA_W-1:0]  o_raddr;

  assign down_val = (!link_ok_q || ras_rd == empty_q) ? nolink_q : ras_rd;
  assign cnt_w    = 32'(cnt_q);
  assign qidx_w   = 32'(qidx_q);
  assign j_w      = 32'(j_q);
  assign issue    = j_q != cnt_q;
  assign o_re     = cmd_i.q_rd || (cmd_i.scan && issue);
  assign o_raddr  = cmd_i.q_rd ? qidx_w[OA_W-1:0] : j_w[OA_W-1:0];

  wll_ram #(.WIDTH(32), .DEPTH(MAX_OUTLETS)) u_self (
    .clk_i  (clk_i),
    .we_i   (cmd_i.app_wr && !full),
    .waddr_i(cnt_w[OA_W-1:0]),
    .wdata_i(oid_q),
    .re_i   (o_re),
    .raddr_i(o_raddr),
    .rdata_o(self_rd)
  );

  wll_ram #(.WIDTH(32), .DEPTH(MAX_OUTLETS)) u_down (
    .clk_i  (clk_i),
    .we_i   (cmd_i.app_wr && !full),
    .waddr_i(cnt_w[OA_W-1:0]),
    .wdata_i(down_val),
    .re_i   (o_re),
    .raddr_i(o_raddr),
    .rdata_o(down_rd)
  );

  // query result and upstream scan; each compare happens in the cycle after its read is issued
  logic [31:0] res_self_q, res_up_q, res_down_q;
  logic        res_status_q;

  assign hit = pend_q && (down_rd == res_self_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      j_q    <= '0;
    end else if (cmd_i.q_cap) begin
      pend_q <= 1'b0;
      j_q    <= '0;
    end else if (cmd_i.scan) begin
      pend_q <= issue && !hit;
      if (issue) begin
        j_q <= j_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_rd && sts_o.q_bad) begin
      res_self_q   <= '0;
      res_up_q     <= '0;
      res_down_q   <= '0;
      res_status_q <= 1'b1;
    end
    if (cmd_i.q_cap) begin
      res_self_q   <= self_rd;
      res_down_q   <= down_rd;
      res_status_q <= 1'b0;
    end
    if (cmd_i.scan && sts_o.scan_end) begin
      res_up_q <= hit ? self_rd : nolink_q;
    end
  end

  // output register
  logic        out_vld_q;
  logic [31:0] out_self_q, out_up_q, out_down_q;
  logic        out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_self_q   <= res_self_q;
      out_up_q     <= res_up_q;
      out_down_q   <= res_down_q;
      out_status_q <= res_status_q;
    end
  end

  assign sts_o.q_bad    = qidx_w >= cnt_w;
  assign sts_o.scan_end = hit || (!pend_q && !issue);
  assign sts_o.out_free = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign self_id_o   = out_self_q;
  assign up_id_o     = out_up_q;
  assign down_id_o   = out_down_q;
  assign status_o    = out_status_q;

endmodule

FILE: src/watershed_link_lookup.sv
// watershed_link_lookup: top level. Keeps a raster of watershed ids and a
// list of outlets, and answers queries for an outlet's self, upstream and
// downstream ids. Channels use valid/stall; item fields are separate ports.
// A configuration write port (valid/ready, index, data) sets grid_rows,
// grid_cols, empty_cell_value and no_link_value; it is always ready and must
// be used only while the block is idle.
// Each request is taken in the idle state; in_stall_o stays high
// while a request is being worked on. An outlet append runs step and bounds,
// address, raster read and table write in order; a clear is done in idle.
// In a query, the upstream search reads the stored downstream table one
// entry per cycle through a single RAM read port and stops at the first
// match. One result per query, none otherwise.
// Results sit in an output register; a stalled result holds, and further
// non-query requests are still taken. A query that finishes while the
// output register is full waits for it to drain.
// Reset clears the outlet list and restores the register defaults; raster
// and outlet contents are undefined until written.
// Depends on wll_pkg, wll_ctrl, wll_dp, wll_ram.
`timescale 1ns / 1ps

module watershed_link_lookup
  import wll_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_OUTLETS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [15:0]          cell_index_i,
  input  logic signed [31:0]   cell_shed_id_i,
  input  logic [7:0]           outlet_row_i,
  input  logic [7:0]           outlet_col_i,
  input  logic [3:0]           outlet_dir_i,
  input  logic signed [31:0]   outlet_id_i,
  input  logic [7:0]           query_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   self_id_o,
  output logic signed [31:0]   up_id_o,
  output logic signed [31:0]   down_id_o,
  output logic                 status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  wll_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .action_i  (action_i),
    .sts_i     (sts),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd)
  );

  wll_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_OUTLETS(MAX_OUTLETS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cell_index_i  (cell_index_i),
    .cell_shed_id_i(cell_shed_id_i),
    .outlet_row_i  (outlet_row_i),
    .outlet_col_i  (outlet_col_i),
    .outlet_dir_i  (outlet_dir_i),
    .outlet_id_i   (outlet_id_i),
    .query_index_i (query_index_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .self_id_o     (self_id_o),
    .up_id_o       (up_id_o),
    .down_id_o     (down_id_o),
    .status_o      (status_o)
  );

  // a request other than clear keeps the input side busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i != ACT_CLEAR) |=> in_stall_o)
    else $error("input not stalled after accepting a request");

  // never overwrite an undelivered result
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while holding a stalled result");

  // only one sequencing step at a time
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ras_wr, cmd.app_step, cmd.app_addr, cmd.app_wr,
              cmd.q_rd, cmd.q_cap, cmd.scan, cmd.out_load}))
    else $error("controller issued overlapping datapath steps");

  // a loaded result shows up on the output
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

FILE: tb/watershed_link_lookup_tb.sv
// watershed_link_lookup_tb: self-checking bench for the watershed link lookup block.
// Drives cell writes, outlet appends, queries and clears under varied idling and
// compares every query result with its own prediction. Depends on wll_pkg and the RTL.
`timescale 1ns / 1ps

module watershed_link_lookup_tb;
  import wll_pkg::*;

  localparam int GRID_MAX    = 256;
  localparam int OUTLETS_MAX = 256;
  localparam int RASTER_SIZE = GRID_MAX * GRID_MAX;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_MAX  = 10;

  localparam logic [3:0] DIR_STILL = 4'd8;
  localparam logic [3:0] DIR_JUNK  = 4'd15;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_UNLOADED = 1'b1;

  typedef struct {
    action_e     act;
    logic [15:0] cell_index;
    logic [31:0] cell_shed_id;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [3:0]  dir;
    logic [31:0] outlet_id;
    logic [7:0]  query_index;
  } shed_req_t;

  typedef struct {
    logic [31:0] self_id;
    logic [31:0] up_id;
    logic [31:0] down_id;
    logic        status;
  } link_result_t;

  class shed_link_board;
    logic [8:0]   grid_rows;
    logic [8:0]   grid_cols;
    logic [31:0]  empty_cell;
    logic [31:0]  no_link;
    logic [31:0]  raster [RASTER_SIZE];
    bit           cell_known [RASTER_SIZE];
    int           known_cells [$];
    logic [31:0]  self_ids [OUTLETS_MAX];
    logic [31:0]  down_ids [OUTLETS_MAX];
    int           loaded;
    int           dropped;
    link_result_t pending_links [$];
    int           failures;

    function new();
      grid_rows  = 9'd256;
      grid_cols  = 9'd256;
      empty_cell = '0;
      no_link    = '1;
      loaded     = 0;
      dropped    = 0;
      failures   = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        REG_GRID_ROWS:  grid_rows = data[8:0];
        REG_GRID_COLS:  grid_cols = data[8:0];
        REG_EMPTY_CELL: empty_cell = data;
        REG_NO_LINK:    no_link = data;
        default: ;
      endcase
    endfunction

    function int rows_used();
      return (grid_rows > GRID_MAX) ? GRID_MAX : int'(grid_rows);
    endfunction

    function int cols_used();
      return (grid_cols > GRID_MAX) ? GRID_MAX : int'(grid_cols);
    endfunction

    function void dir_step(logic [3:0] dir, output int dr, output int dc);
      dr = 0;
      dc = 0;
      case (dir)
        DIR_NW: begin dr = -1; dc = -1; end
        DIR_N:  begin dr = -1; dc = 0;  end
        DIR_NE: begin dr = -1; dc = 1;  end
        DIR_W:  begin dr = 0;  dc = -1; end
        DIR_E:  begin dr = 0;  dc = 1;  end
        DIR_SW: begin dr = 1;  dc = -1; end
        DIR_S:  begin dr = 1;  dc = 0;  end
        DIR_SE: begin dr = 1;  dc = 1;  end
        default: ;
      endcase
    endfunction

    // Raster address one step away, or -1 when the step leaves the grid.
    function int target_cell(logic [7:0] row, logic [7:0] col, logic [3:0] dir);
      int dr, dc, r, c;
      dir_step(dir, dr, dc);
      r = int'(row) + dr;
      c = int'(col) + dc;
      if (r < 0 || r >= rows_used() || c < 0 || c >= cols_used()) return -1;
      return r * cols_used() + c;
    endfunction

    function link_result_t lookup(logic [7:0] q);
      link_result_t res;
      res.self_id = '0;
      res.up_id   = '0;
      res.down_id = '0;
      res.status  = STATUS_UNLOADED;
      if (int'(q) >= loaded) return res;
      res.self_id = self_ids[q];
      res.down_id = down_ids[q];
      res.up_id   = no_link;
      res.status  = STATUS_OK;
      // first outlet in load order that drains into this one
      for (int j = 0; j < loaded; j++) begin
        if (down_ids[j] == self_ids[q]) begin
          res.up_id = self_ids[j];
          break;
        end
      end
      return res;
    endfunction

    function void take_request(shed_req_t r);
      int a;
      case (r.act)
        ACT_WRITE: begin
          raster[r.cell_index] = r.cell_shed_id;
          if (!cell_known[r.cell_index]) begin
            cell_known[r.cell_index] = 1'b1;
            known_cells.push_back(int'(r.cell_index));
          end
        end
        ACT_APPEND: begin
          if (loaded < OUTLETS_MAX) begin
            a = target_cell(r.row, r.col, r.dir);
            self_ids[loaded] = r.outlet_id;
            if (a < 0 || raster[a] == empty_cell) down_ids[loaded] = no_link;
            else down_ids[loaded] = raster[a];
            loaded++;
          end else begin
            dropped++;
          end
        end
        ACT_CLEAR: loaded = 0;
        default: pending_links.push_back(lookup(r.query_index));
      endcase
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    function void check_link_result(link_result_t got);
      link_result_t want;
      if (pending_links.size() == 0) begin
        report($sformatf("result with no query waiting: self %0d up %0d down %0d status %0d",
                         $signed(got.self_id), $signed(got.up_id), $signed(got.down_id),
                         got.status));
        return;
      end
      want = pending_links.pop_front();
      if (got.self_id !== want.self_id || got.up_id !== want.up_id ||
          got.down_id !== want.down_id || got.status !== want.status)
        report($sformatf({"query result (expected/actual): self %0d/%0d up %0d/%0d ",
                          "down %0d/%0d status %0d/%0d"},
                         $signed(want.self_id), $signed(got.self_id),
                         $signed(want.up_id), $signed(got.up_id),
                         $signed(want.down_id), $signed(got.down_id),
                         want.status, got.status));
    endfunction

    function void finish_check();
      if (pending_links.size() != 0)
        report($sformatf("%0d query results never arrived", pending_links.size()));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = '0;
  logic [15:0]          cell_index = '0;
  logic signed [31:0]   cell_shed_id = '0;
  logic [7:0]           outlet_row = '0;
  logic [7:0]           outlet_col = '0;
  logic [3:0]           outlet_dir = '0;
  logic signed [31:0]   outlet_id = '0;
  logic [7:0]           query_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   self_id;
  logic signed [31:0]   up_id;
  logic signed [31:0]   down_id;
  logic                 status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  shed_link_board sb = new();
  link_result_t   seen;
  logic [31:0]    id_pool [10];
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             hold_cycles = 0;
  int             cycle_count = 0;

  watershed_link_lookup uut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .cell_index_i   (cell_index),
    .cell_shed_id_i (cell_shed_id),
    .outlet_row_i   (outlet_row),
    .outlet_col_i   (outlet_col),
    .outlet_dir_i   (outlet_dir),
    .outlet_id_i    (outlet_id),
    .query_index_i  (query_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .self_id_o      (self_id),
    .up_id_o        (up_id),
    .down_id_o      (down_id),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: hold off for a long stretch when asked, else stall at random.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      seen.self_id = self_id;
      seen.up_id   = up_id;
      seen.down_id = down_id;
      seen.status  = status;
      sb.check_link_result(seen);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic shed_req_t noise_req(action_e act);
    shed_req_t r;
    r.act          = act;
    r.cell_index   = 16'($urandom);
    r.cell_shed_id = $urandom;
    r.row          = 8'($urandom);
    r.col          = 8'($urandom);
    r.dir          = 4'($urandom);
    r.outlet_id    = $urandom;
    r.query_index  = 8'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] pick_id();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return id_pool[$urandom_range(9)];
    if (roll < 80) return sb.no_link;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_cell_id();
    if ($urandom_range(99) < 15) return sb.empty_cell;
    return pick_id();
  endfunction

  task automatic send(input shed_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    action       <= r.act;
    cell_index   <= r.cell_index;
    cell_shed_id <= r.cell_shed_id;
    outlet_row   <= r.row;
    outlet_col   <= r.col;
    outlet_dir   <= r.dir;
    outlet_id    <= r.outlet_id;
    query_index  <= r.query_index;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.take_request(r);
  endtask

  task automatic write_cell(input int addr, input logic [31:0] id);
    shed_req_t r;
    r = noise_req(ACT_WRITE);
    r.cell_index   = 16'(addr);
    r.cell_shed_id = id;
    send(r);
  endtask

  // Fill the downstream cell first if the step lands on one never written.
  task automatic append_outlet(input logic [7:0] row, input logic [7:0] col,
                               input logic [3:0] dir, input logic [31:0] id);
    shed_req_t r;
    int a;
    a = sb.target_cell(row, col, dir);
    if (a >= 0 && !sb.cell_known[a]) write_cell(a, pick_cell_id());
    r = noise_req(ACT_APPEND);
    r.row       = row;
    r.col       = col;
    r.dir       = dir;
    r.outlet_id = id;
    send(r);
  endtask

  task automatic query_outlet(input logic [7:0] q);
    shed_req_t r;
    r = noise_req(ACT_QUERY);
    r.query_index = q;
    send(r);
  endtask

  task automatic clear_outlets();
    send(noise_req(ACT_CLEAR));
  endtask

  task automatic random_write();
    int rc, a;
    rc = sb.rows_used() * sb.cols_used();
    if (rc > 0 && $urandom_range(1) == 1) a = $urandom_range(rc - 1);
    else a = $urandom_range(RASTER_SIZE - 1);
    write_cell(a, pick_cell_id());
  endtask

  task automatic random_append();
    int a, dr, dc, tr, tc, cols;
    logic [3:0] dir;
    logic [7:0] row, col;
    row  = 8'($urandom);
    col  = 8'($urandom);
    dir  = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
    cols = sb.cols_used();
    // aim half the appends at cells that already hold an id
    if (sb.known_cells.size() > 0 && cols > 0 && $urandom_range(1) == 1) begin
      a   = sb.known_cells[$urandom_range(sb.known_cells.size() - 1)];
      dir = 4'($urandom_range(DIR_STILL));
      sb.dir_step(dir, dr, dc);
      tr = a / cols - dr;
      tc = a % cols - dc;
      if (tr >= 0 && tr < GRID_MAX && tc >= 0 && tc < GRID_MAX) begin
        row = 8'(tr);
        col = 8'(tc);
      end
    end
    append_outlet(row, col, dir, pick_id());
  endtask

  task automatic random_query();
    if (sb.loaded > 0 && $urandom_range(99) < 75) query_outlet(8'($urandom_range(sb.loaded - 1)));
    else query_outlet(8'($urandom));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_links.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [7:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic load_grid(input logic [8:0] rows, input logic [8:0] cols,
                           input logic [31:0] empty_val, input logic [31:0] link_val);
    cfg_put(REG_GRID_ROWS, {23'($urandom), rows});
    cfg_put(REG_GRID_COLS, {23'($urandom), cols});
    cfg_put(REG_EMPTY_CELL, empty_val);
    cfg_put(REG_NO_LINK, link_val);
    cfg_put(8'($urandom_range(255, REG_NO_LINK + 1)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_checks();
    write_cell(0, 32'd100);
    write_cell(1, 32'd0);
    write_cell(GRID_MAX, 32'h8000_0000);
    write_cell(RASTER_SIZE - 1, 32'h7FFF_FFFF);
    query_outlet(8'd0);
    append_outlet(8'd0, 8'd0, DIR_NW, 32'd7);
    append_outlet(8'd1, 8'd1, DIR_NW, 32'h8000_0000);
    append_outlet(8'd255, 8'd254, DIR_E, 32'd100);
    append_outlet(8'd254, 8'd254, DIR_SE, 32'h7FFF_FFFF);
    append_outlet(8'd1, 8'd0, DIR_NE, '1);
    append_outlet(8'd0, 8'd1, DIR_SW, 32'd5);
    append_outlet(8'd255, 8'd255, DIR_S, 32'd6);
    append_outlet(8'd255, 8'd255, DIR_STILL, 32'd8);
    append_outlet(8'd255, 8'd255, DIR_JUNK, 32'd9);
    append_outlet(8'd1, 8'd1, DIR_W, 32'd10);
    append_outlet(8'd1, 8'd0, DIR_N, 32'd11);
    query_outlet(8'd1);
    query_outlet(8'd2);
    query_outlet(8'd3);
    query_outlet(8'd4);
    query_outlet(8'd255);
    clear_outlets();
    query_outlet(8'd0);
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall);
    int roll;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) wait_results();
      roll = $urandom_range(99);
      // no clears until eight appends have been dropped on a full list
      if (sb.dropped < 8) begin
        if (roll < 5) random_write();
        else if (roll < 80) random_append();
        else random_query();
      end else if (roll < 30) begin
        random_write();
      end else if (roll < 63) begin
        random_append();
      end else if (roll < 96) begin
        random_query();
      end else begin
        clear_outlets();
      end
    end
    wait_results();
  endtask

  initial begin
    id_pool[0] = 32'd0;
    id_pool[1] = 32'd1;
    id_pool[2] = '1;
    id_pool[3] = 32'd100;
    id_pool[4] = 32'h7FFF_FFFF;
    id_pool[5] = 32'h8000_0000;
    for (int i = 6; i < 10; i++) id_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    directed_checks();
    wait_results();
    load_grid(9'd256, 9'd256, 32'd0, '1);
    run_phase(300, 0, 0);
    load_grid(9'd16, 9'd20, 32'h8000_0000, 32'h7FFF_FFFF);
    run_phase(150, 52, 0);
    load_grid(9'd1, 9'd256, 32'h7FFF_FFFF, 32'h8000_0000);
    run_phase(150, 0, 52);
    load_grid(9'd300, 9'd1, $urandom, 32'd0);
    run_phase(150, 31, 31);
    load_grid(9'd0, 9'd511, 32'd5, 32'd5);
    hold_cycles = 600;
    run_phase(100, 0, 0);
    load_grid(9'($urandom_range(256, 1)), 9'($urandom_range(256, 1)), $urandom, $urandom);
    run_phase(100, 31, 31);
    sb.finish_check();
    if (sb.failures == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
